// ===== rtl/piecewise_linear_level_map_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the level map
// Shorthand for the clocked properties used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_LEVEL_MAP_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_LEVEL_MAP_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define PLM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define PLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define PLM_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/plm_pkg.sv =====
// ----------------------------------------------------------------------------
// plm_pkg
// Shared types, constants and arithmetic helpers of the level map.
// ----------------------------------------------------------------------------
package plm_pkg;

  localparam int unsigned DATA_W     = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_FIRST = 3'd1;

  localparam logic [DATA_W-1:0] FULL_SCALE = 16'hFFFF;

  // Divider: 32-bit magnitude quotient, four quotient bits per stage.
  localparam int unsigned PROD_W     = 2 * DATA_W;
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = PROD_W / DIV_BITS;

  // Raw, search, difference and product stages, the divider, the output.
  localparam int unsigned PIPE_DEPTH = 5 + DIV_STAGES;

  typedef struct packed {
    logic              neg;
    logic              past_end;
    logic              den_zero;
    logic [DATA_W-1:0] y0;
    logic [DATA_W-1:0] y1;
  } plm_side_t;

  typedef struct packed {
    logic [PROD_W-1:0] num;
    logic [DATA_W-1:0] den;
    plm_side_t         side;
  } plm_div_req_t;

  typedef struct packed {
    logic [PROD_W-1:0] quo;
    plm_side_t         side;
  } plm_div_rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0] rem;
    logic [PROD_W-1:0] nq;
  } plm_div_acc_t;

  // One restoring step: the numerator leaves nq at the top, quotient bits
  // enter at the bottom.
  function automatic plm_div_acc_t plm_div_step(plm_div_acc_t acc,
                                                logic [DATA_W-1:0] den);
    logic [DATA_W:0] trial;
    plm_div_acc_t    res;
    trial  = {acc.rem, acc.nq[PROD_W-1]};
    res.nq = {acc.nq[PROD_W-2:0], 1'b0};
    if (trial >= {1'b0, den}) begin
      trial     = trial - {1'b0, den};
      res.nq[0] = 1'b1;
    end
    res.rem = trial[DATA_W-1:0];
    return res;
  endfunction

  // Returns {sign, magnitude} of a - b.
  function automatic logic [DATA_W:0] plm_abs_diff(logic [DATA_W-1:0] a,
                                                   logic [DATA_W-1:0] b);
    logic [DATA_W:0] d;
    logic [DATA_W:0] m;
    d = {1'b0, a} - {1'b0, b};
    m = d[DATA_W] ? ({(DATA_W+1){1'b0}} - d) : d;
    return {d[DATA_W], m[DATA_W-1:0]};
  endfunction

endpackage

// ===== rtl/plm_cfg.sv =====
// ----------------------------------------------------------------------------
// plm_cfg
// Breakpoint registers and the curve built from them, implicit end points
// included.
// ----------------------------------------------------------------------------
module plm_cfg import plm_pkg::*; #(
  parameter int unsigned MAX_POINTS = 6,
  localparam int unsigned CURVE_N = MAX_POINTS + 2,
  localparam int unsigned CNT_W   = $clog2(CURVE_N + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  input  logic [CFG_IDX_W-1:0]             cfg_index,
  input  logic [CFG_DATA_W-1:0]            cfg_data,
  output logic [CURVE_N-1:0][DATA_W-1:0]   curve_x,
  output logic [CURVE_N-1:0][DATA_W-1:0]   curve_y,
  output logic [CNT_W-1:0]                 curve_n
);

  localparam logic [CFG_IDX_W-1:0] MAXP = CFG_IDX_W'(MAX_POINTS);

  logic [CFG_IDX_W-1:0]  count_r;
  logic [CFG_DATA_W-1:0] point_r [MAX_POINTS];
  logic [CFG_IDX_W-1:0]  used;
  logic                  has_zero;
  logic                  has_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < MAX_POINTS; i++) begin
        point_r[i] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index == REG_POINT_COUNT) begin
        count_r <= cfg_data[CFG_IDX_W-1:0];
      end
      for (int i = 0; i < MAX_POINTS; i++) begin
        if (cfg_index == REG_POINT_FIRST + CFG_IDX_W'(i)) begin
          point_r[i] <= cfg_data;
        end
      end
    end
  end

  always_comb begin
    used     = (count_r > MAXP) ? MAXP : count_r;
    has_zero = 1'b0;
    has_full = 1'b0;
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (CFG_IDX_W'(i) < used) begin
        if (point_r[i][CFG_DATA_W-1:DATA_W] == '0) begin
          has_zero = 1'b1;
        end
        if (point_r[i][CFG_DATA_W-1:DATA_W] == FULL_SCALE) begin
          has_full = 1'b1;
        end
      end
    end
  end

  assign curve_n = CNT_W'(used) + CNT_W'(!has_zero) + CNT_W'(!has_full);

  // Slot j holds user point j when key 0 is present, else user point j-1
  // behind the implicit origin. Slots past the user points hold the
  // implicit full-scale point.
  for (genvar j = 0; j < CURVE_N; j++) begin : g_slot
    logic [CFG_DATA_W-1:0] at_j;
    logic [CFG_DATA_W-1:0] at_prev;
    logic [CFG_DATA_W-1:0] user_pt;
    logic [DATA_W-1:0]     slot_x;
    logic [DATA_W-1:0]     slot_y;

    if (j < MAX_POINTS) begin : g_at
      assign at_j = point_r[j];
    end else begin : g_at_none
      assign at_j = '0;
    end

    if (j >= 1 && j - 1 < MAX_POINTS) begin : g_prev
      assign at_prev = point_r[j-1];
    end else begin : g_prev_none
      assign at_prev = '0;
    end

    always_comb begin
      user_pt = has_zero ? at_j : at_prev;
      if (!has_zero && j == 0) begin
        slot_x = '0;
        slot_y = '0;
      end else if (CNT_W'(j) < CNT_W'(used) + CNT_W'(!has_zero)) begin
        slot_x = user_pt[CFG_DATA_W-1:DATA_W];
        slot_y = user_pt[DATA_W-1:0];
      end else begin
        slot_x = FULL_SCALE;
        slot_y = FULL_SCALE;
      end
    end

    assign curve_x[j] = slot_x;
    assign curve_y[j] = slot_y;
  end

endmodule

// ===== rtl/plm_seg.sv =====
// ----------------------------------------------------------------------------
// plm_seg
// Front pipeline: registers the raw level, finds its segment, forms the
// signed differences and multiplies them into the divider request.
// ----------------------------------------------------------------------------
module plm_seg import plm_pkg::*; #(
  parameter int unsigned MAX_POINTS = 6,
  localparam int unsigned CURVE_N = MAX_POINTS + 2,
  localparam int unsigned CNT_W   = $clog2(CURVE_N + 1),
  localparam int unsigned SEL_W   = $clog2(CURVE_N)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [DATA_W-1:0]              in_raw,
  input  logic [CURVE_N-1:0][DATA_W-1:0] curve_x,
  input  logic [CURVE_N-1:0][DATA_W-1:0] curve_y,
  input  logic [CNT_W-1:0]               curve_n,
  output logic                           req_valid,
  input  logic                           req_ready,
  output plm_div_req_t                   req
);

  logic rdy1, rdy2, rdy3, rdy4;

  // Stage 1: raw level.
  logic              s1_v_r;
  logic [DATA_W-1:0] s1_raw_r;

  // Stage 2: segment end points.
  logic              s2_v_r;
  logic [DATA_W-1:0] s2_raw_r, s2_x0_r, s2_y0_r, s2_x1_r, s2_y1_r;
  logic              s2_past_r;
  logic [DATA_W-1:0] s2_x0_nxt, s2_y0_nxt, s2_x1_nxt, s2_y1_nxt;
  logic              s2_past_nxt;
  logic [SEL_W-1:0]  sel, sel_prev;

  // Stage 3: magnitudes of the differences.
  logic              s3_v_r;
  logic [DATA_W-1:0] s3_dy_r, s3_dr_r, s3_den_r;
  plm_side_t         s3_side_r;
  logic [DATA_W:0]   dy_nxt, dr_nxt, dd_nxt;
  plm_side_t         s3_side_nxt;

  // Stage 4: product.
  logic              s4_v_r;
  logic [PROD_W-1:0] s4_prod_r;
  logic [DATA_W-1:0] s4_den_r;
  plm_side_t         s4_side_r;

  assign rdy4     = !s4_v_r || req_ready;
  assign rdy3     = !s3_v_r || rdy4;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;

  // The first curve point from the second on whose key is at or above the
  // raw level closes the segment.
  always_comb begin
    s2_past_nxt = 1'b1;
    sel         = '0;
    sel_prev    = '0;
    for (int i = CURVE_N - 1; i >= 1; i--) begin
      if (CNT_W'(i) < curve_n && curve_x[i] >= s1_raw_r) begin
        s2_past_nxt = 1'b0;
        sel         = SEL_W'(i);
        sel_prev    = SEL_W'(i - 1);
      end
    end
    s2_x1_nxt = curve_x[sel];
    s2_y1_nxt = curve_y[sel];
    s2_x0_nxt = curve_x[sel_prev];
    s2_y0_nxt = curve_y[sel_prev];
  end

  always_comb begin
    dy_nxt               = plm_abs_diff(s2_y1_r, s2_y0_r);
    dr_nxt               = plm_abs_diff(s2_raw_r, s2_x0_r);
    dd_nxt               = plm_abs_diff(s2_x1_r, s2_x0_r);
    s3_side_nxt.neg      = dy_nxt[DATA_W] ^ dr_nxt[DATA_W] ^ dd_nxt[DATA_W];
    s3_side_nxt.past_end = s2_past_r;
    s3_side_nxt.den_zero = (s2_x1_r == s2_x0_r);
    s3_side_nxt.y0       = s2_y0_r;
    s3_side_nxt.y1       = s2_y1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy3) begin
        s3_v_r <= s2_v_r;
      end
      if (rdy4) begin
        s4_v_r <= s3_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_raw_r <= in_raw;
    end
    if (rdy2) begin
      s2_raw_r  <= s1_raw_r;
      s2_x0_r   <= s2_x0_nxt;
      s2_y0_r   <= s2_y0_nxt;
      s2_x1_r   <= s2_x1_nxt;
      s2_y1_r   <= s2_y1_nxt;
      s2_past_r <= s2_past_nxt;
    end
    if (rdy3) begin
      s3_dy_r   <= dy_nxt[DATA_W-1:0];
      s3_dr_r   <= dr_nxt[DATA_W-1:0];
      s3_den_r  <= dd_nxt[DATA_W-1:0];
      s3_side_r <= s3_side_nxt;
    end
    if (rdy4) begin
      s4_prod_r <= s3_dy_r * s3_dr_r;
      s4_den_r  <= s3_den_r;
      s4_side_r <= s3_side_r;
    end
  end

  assign req_valid = s4_v_r;
  assign req.num   = s4_prod_r;
  assign req.den   = s4_den_r;
  assign req.side  = s4_side_r;

endmodule

// ===== rtl/plm_div.sv =====
// ----------------------------------------------------------------------------
// plm_div
// Pipelined restoring divider on magnitudes, four quotient bits per
// stage, with the segment sideband carried alongside.
// ----------------------------------------------------------------------------
module plm_div import plm_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         req_valid,
  output logic         req_ready,
  input  plm_div_req_t req,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output plm_div_rsp_t rsp
);

  logic              v_r    [DIV_STAGES];
  plm_div_acc_t      acc_r  [DIV_STAGES];
  logic [DATA_W-1:0] den_r  [DIV_STAGES];
  plm_side_t         side_r [DIV_STAGES];
  logic [DIV_STAGES:0] rdy;

  assign rdy[DIV_STAGES] = rsp_ready;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic              v_in;
    plm_div_acc_t      acc_in;
    logic [DATA_W-1:0] den_in;
    plm_side_t         side_in;
    plm_div_acc_t      acc_nxt;

    if (s == 0) begin : g_first
      assign v_in    = req_valid;
      assign acc_in  = {{DATA_W{1'b0}}, req.num};
      assign den_in  = req.den;
      assign side_in = req.side;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign acc_in  = acc_r[s-1];
      assign den_in  = den_r[s-1];
      assign side_in = side_r[s-1];
    end

    always_comb begin
      acc_nxt = acc_in;
      for (int k = 0; k < DIV_BITS; k++) begin
        acc_nxt = plm_div_step(acc_nxt, den_in);
      end
    end

    assign rdy[s] = !v_r[s] || rdy[s+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        acc_r[s]  <= acc_nxt;
        den_r[s]  <= den_in;
        side_r[s] <= side_in;
      end
    end
  end

  assign req_ready = rdy[0];
  assign rsp_valid = v_r[DIV_STAGES-1];
  assign rsp.quo   = acc_r[DIV_STAGES-1].nq;
  assign rsp.side  = side_r[DIV_STAGES-1];

endmodule

// ===== rtl/piecewise_linear_level_map_top.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_level_map_top
// Maps a raw level to a duty level through a breakpoint curve. The block
// takes one raw level per clock while the output side keeps up, and passes
// it through the input register, the segment search, the differences, the
// 16x16 product, the divider stages (four quotient bits per stage over a
// 32-bit quotient) and the output register. Every stage stalls on its own,
// so empty stages keep filling while a result waits at the output.
// Breakpoints are written through the cfg_ port, which is always ready;
// write them only while no request is in flight. The breakpoint registers
// and the valid bits reset to zero, the datapath registers are not reset,
// and there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module piecewise_linear_level_map_top import plm_pkg::*; #(
  parameter int unsigned MAX_POINTS = 6
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_W-1:0]     in_tdata,   // [15:0] raw_level
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // [15:0] duty_level
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CURVE_N = MAX_POINTS + 2;
  localparam int unsigned CNT_W   = $clog2(CURVE_N + 1);
  localparam int unsigned SUM_W   = PROD_W + 2;

  logic [CURVE_N-1:0][DATA_W-1:0] curve_x;
  logic [CURVE_N-1:0][DATA_W-1:0] curve_y;
  logic [CNT_W-1:0]               curve_n;

  logic         req_valid, req_ready;
  plm_div_req_t req;
  logic         rsp_valid, rsp_ready;
  plm_div_rsp_t rsp;

  logic              out_v_r;
  logic [DATA_W-1:0] out_data_r;
  logic [DATA_W-1:0] out_data_nxt;
  logic [SUM_W-1:0]  q_ext;
  logic [SUM_W-1:0]  sum;

  assign cfg_ready = 1'b1;

  plm_cfg #(.MAX_POINTS(MAX_POINTS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .curve_x   (curve_x),
    .curve_y   (curve_y),
    .curve_n   (curve_n)
  );

  plm_seg #(.MAX_POINTS(MAX_POINTS)) u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_raw    (in_tdata),
    .curve_x   (curve_x),
    .curve_y   (curve_y),
    .curve_n   (curve_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  plm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign rsp_ready = !out_v_r || out_tready;

  // y0 + signed quotient, 16-bit clamp; full scale past end, y1 if x1==x0.
  always_comb begin
    q_ext = {2'b00, rsp.quo};
    sum   = {{(SUM_W-DATA_W){1'b0}}, rsp.side.y0}
          + (rsp.side.neg ? ({SUM_W{1'b0}} - q_ext) : q_ext);
    if (rsp.side.past_end) begin
      out_data_nxt = FULL_SCALE;
    end else if (rsp.side.den_zero) begin
      out_data_nxt = rsp.side.y1;
    end else if (sum[SUM_W-1]) begin
      out_data_nxt = '0;
    end else if (|sum[SUM_W-2:DATA_W]) begin
      out_data_nxt = {DATA_W{1'b1}};
    end else begin
      out_data_nxt = sum[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rsp_ready) begin
      out_v_r <= rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_ready) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/plm_checker.sv =====
// ----------------------------------------------------------------------------
// plm_checker
// Port-level checks of the level map, bound to the top level.
// ----------------------------------------------------------------------------
`include "piecewise_linear_level_map_top_assert.svh"

module plm_checker import plm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [DATA_W-1:0] out_tdata
);

  localparam int unsigned CW = $clog2(PIPE_DEPTH + 1);

  logic [CW-1:0] inflight_r;
  logic [CW-1:0] inflight_nxt;

  // Requests taken in minus results handed out.
  always_comb begin
    inflight_nxt = inflight_r;
    if (in_tvalid && in_tready) begin
      inflight_nxt = inflight_nxt + CW'(1);
    end
    if (out_tvalid && out_tready) begin
      inflight_nxt = inflight_nxt - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  `PLM_ASSERT_ALWAYS(a_reset_clears, !rst_n, !out_tvalid, "result valid after reset")
  `PLM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
  `PLM_ASSERT_NOW(a_no_phantom, out_tvalid, inflight_r != '0, "result without a request in flight")
  `PLM_ASSERT_NOW(a_full_only, !in_tready, out_tvalid && !out_tready, "input stalled while output free")
  `PLM_ASSERT_NOW(a_depth, 1'b1, inflight_r <= CW'(PIPE_DEPTH), "more requests in flight than stages")

endmodule

bind piecewise_linear_level_map_top plm_checker u_plm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
